/* sv/keyframe_interpolator_assert.svh */
// Assertion macros used by the checker file kfi_checker.sv.
`ifndef KEYFRAME_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_INTERPOLATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define KFI_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define KFI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/kfi_pkg.sv */
package kfi_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SINE_STEPS = 16;

  // Differences of two 32-bit fields
  localparam int DIFF_W = 33;
  // Dividend |dq| << FRAC_BITS, also the quotient width
  localparam int NUM_W  = DIFF_W + FRAC_BITS;
  // Ease weight in Q1.30, 0 .. 1.0
  localparam int W_W    = 31;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] Q30_PI  = 32'd3373259426;

  typedef enum logic {
    MODE_LINEAR = 1'b0,
    MODE_SINE   = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic               zero_span;
    logic signed [31:0] value_start;
    logic               dv_neg;
    logic [DIFF_W-1:0]  dv_mag;
    logic               fac_neg;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [NUM_W-1:0]  fac_mag;
  } pass_t;

endpackage

/* sv/keyframe_interpolator.sv */
// Keyframe interpolator: each item gives two keyframes, a query frame and a
// mode, all signed Q16.16, and yields one result item with the interpolated
// value (linear, or the rising half of a cosine ease), a zero_span flag for
// equal keyframe times and a saturated flag when the value was clamped to
// 32 bits. The block is a fully pipelined datapath: a new item is taken in
// every cycle while the pipe is not frozen. The pipeline depth is set by the
// restoring divider, one quotient bit per stage, and by the cosine series,
// three stages per Taylor term. Both modes travel the same stages, so results
// leave in input order. When result_stall holds a waiting result the whole
// pipe freezes; one extra input item is parked in a skid register, so
// query_stall is a registered signal and never follows result_stall
// combinationally.
module keyframe_interpolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               query_valid,
  output logic               query_stall,
  input  logic               mode,
  input  logic signed [31:0] frame_start,
  input  logic signed [31:0] frame_end,
  input  logic signed [31:0] value_start,
  input  logic signed [31:0] value_end,
  input  logic signed [31:0] query_frame,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] value,
  output logic               zero_span,
  output logic               saturated
);

  localparam int NW = kfi_pkg::NUM_W;
  localparam int DW = kfi_pkg::DIFF_W;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] frame_start;
    logic signed [31:0] frame_end;
    logic signed [31:0] value_start;
    logic signed [31:0] value_end;
    logic signed [31:0] query_frame;
  } query_t;

  // Advance the pipe unless a finished result is being held.
  logic en;
  assign en = !(result_valid && result_stall);

  // Skid register: catch the item offered while the pipe is frozen.
  logic   skid_valid;
  query_t skid;
  query_t incoming;
  query_t src;
  logic   src_valid;

  assign query_stall = skid_valid;

  always_comb begin
    incoming.mode        = mode;
    incoming.frame_start = frame_start;
    incoming.frame_end   = frame_end;
    incoming.value_start = value_start;
    incoming.value_end   = value_end;
    incoming.query_frame = query_frame;
    src       = skid_valid ? skid : incoming;
    src_valid = skid_valid || query_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (query_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && query_valid && !skid_valid) begin
      skid <= incoming;
    end
  end

  // Front stage: form the span, the query offset and the value delta, and
  // take their magnitudes for the unsigned divider and multiplier.
  logic signed [DW-1:0] span;
  logic signed [DW-1:0] dq;
  logic signed [DW-1:0] dv;
  logic [DW-1:0]        span_mag;
  logic [DW-1:0]        dq_mag;
  logic [DW-1:0]        dv_mag;

  always_comb begin
    span     = DW'(src.frame_end) - DW'(src.frame_start);
    dq       = DW'(src.query_frame) - DW'(src.frame_start);
    dv       = DW'(src.value_end) - DW'(src.value_start);
    span_mag = span[DW-1] ? DW'(-span) : DW'(span);
    dq_mag   = dq[DW-1] ? DW'(-dq) : DW'(dq);
    dv_mag   = dv[DW-1] ? DW'(-dv) : DW'(dv);
  end

  logic            a_valid;
  logic [NW-1:0]   a_num;
  logic [DW-1:0]   a_den;
  kfi_pkg::side_t  a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_num              <= {dq_mag, {kfi_pkg::FRAC_BITS{1'b0}}};
      a_den              <= span_mag;
      a_side.mode        <= kfi_pkg::mode_t'(src.mode);
      a_side.zero_span   <= (span == '0);
      a_side.value_start <= src.value_start;
      a_side.dv_neg      <= dv[DW-1];
      a_side.dv_mag      <= dv_mag;
      a_side.fac_neg     <= dq[DW-1] ^ span[DW-1];
    end
  end

  // Fraction: |dq| << FRAC_BITS divided by |span|.
  logic            d_valid;
  logic [NW-1:0]   d_quot;
  kfi_pkg::side_t  d_side;
  kfi_pkg::pass_t  d_pass;

  kfi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_valid),
    .num       (a_num),
    .den       (a_den),
    .side_in   (a_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .side_out  (d_side)
  );

  always_comb begin
    d_pass.side    = d_side;
    d_pass.fac_mag = d_quot;
  end

  // Ease weight; the linear fraction rides along unchanged.
  logic                      e_valid;
  logic [kfi_pkg::W_W-1:0]   e_weight;
  kfi_pkg::pass_t            e_pass;

  kfi_ease u_ease (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .pass_in   (d_pass),
    .out_valid (e_valid),
    .weight    (e_weight),
    .pass_out  (e_pass)
  );

  // Scale the delta, add the start value and saturate; its last stage is
  // the output register.
  kfi_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .pass_in   (e_pass),
    .weight    (e_weight),
    .out_valid (result_valid),
    .value     (value),
    .zero_span (zero_span),
    .saturated (saturated)
  );

endmodule

/* sv/kfi_div.sv */
module kfi_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [kfi_pkg::NUM_W-1:0]   num,
  input  logic [kfi_pkg::DIFF_W-1:0]  den,
  input  kfi_pkg::side_t              side_in,
  output logic                        out_valid,
  output logic [kfi_pkg::NUM_W-1:0]   quot,
  output kfi_pkg::side_t              side_out
);

  localparam int NW = kfi_pkg::NUM_W;
  localparam int DW = kfi_pkg::DIFF_W;

  typedef struct packed {
    logic [DW-1:0]   rem;
    logic [NW-1:0]   num;
    logic [NW-1:0]   quo;
    logic [DW-1:0]   den;
    kfi_pkg::side_t  side;
  } dstage_t;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic dstage_t div_step(dstage_t s);
    dstage_t     r;
    logic [DW:0] part;
    logic [DW:0] diff;
    logic        ge;
    r    = s;
    part = {s.rem, s.num[NW-1]};
    diff = part - {1'b0, s.den};
    ge   = part >= {1'b0, s.den};
    r.rem = ge ? diff[DW-1:0] : part[DW-1:0];
    r.num = {s.num[NW-2:0], 1'b0};
    r.quo = {s.quo[NW-2:0], ge};
    return r;
  endfunction

  dstage_t       init;
  dstage_t       st [NW];
  logic [NW-1:0] vld;

  always_comb begin
    init.rem  = '0;
    init.num  = num;
    init.quo  = '0;
    init.den  = den;
    init.side = side_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_step(init);
      for (int i = 1; i < NW; i++) begin
        st[i] <= div_step(st[i-1]);
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quot      = st[NW-1].quo;
  assign side_out  = st[NW-1].side;

endmodule

/* sv/kfi_ease.sv */
module kfi_ease (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  kfi_pkg::pass_t            pass_in,
  output logic                      out_valid,
  output logic [kfi_pkg::W_W-1:0]   weight,
  output kfi_pkg::pass_t            pass_out
);

  localparam int F    = kfi_pkg::FRAC_BITS;
  localparam int SS   = kfi_pkg::SINE_STEPS;
  localparam int PH   = F + 1;
  localparam int LAT  = 3 * SS + 4;
  localparam logic [PH-1:0] ONE_F   = PH'(1) << F;
  localparam logic [30:0]   ONE     = kfi_pkg::Q30_ONE;
  localparam logic [30:0]   HALF    = kfi_pkg::Q30_ONE >> 1;

  typedef struct packed {
    logic [31:0]        x2;
    logic [31:0]        term;
    logic [31:0]        n;
    logic [31:0]        q0;
    logic signed [33:0] c;
    logic               flip;
    kfi_pkg::pass_t     pass;
  } tstage_t;

  logic [LAT-1:0] vld;

  // phase fold
  logic [PH-1:0] ph;
  logic [PH-1:0] tf;
  logic [30:0]   uw;
  logic          fl;
  logic [30:0]   uf;

  logic [29:0]    s0_u;
  logic           s0_flip;
  kfi_pkg::pass_t s0_pass;
  logic [30:0]    s1_x;
  logic           s1_flip;
  kfi_pkg::pass_t s1_pass;
  logic [61:0]    xp;
  logic [61:0]    x2p;

  tstage_t tst [3*SS+1];

  always_comb begin
    ph = pass_in.fac_mag[PH-1:0];
    if (pass_in.side.fac_neg) begin
      ph = '0 - ph;
    end
    tf = (ph > ONE_F) ? ('0 - ph) : ph;
    uw = 31'(tf) << (30 - F);
    fl = uw > HALF;
    uf = fl ? (ONE - uw) : uw;
  end

  assign xp  = 62'(s0_u) * 62'(kfi_pkg::Q30_PI);
  assign x2p = 62'(s1_x) * 62'(s1_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_u    <= uf[29:0];
      s0_flip <= fl;
      s0_pass <= pass_in;
      s1_x    <= xp[60:30];
      s1_flip <= s0_flip;
      s1_pass <= s0_pass;
      tst[0].x2   <= x2p[61:30];
      tst[0].term <= 32'(ONE);
      tst[0].n    <= '0;
      tst[0].q0   <= '0;
      tst[0].c    <= $signed(34'(ONE));
      tst[0].flip <= s1_flip;
      tst[0].pass <= s1_pass;
    end
  end

  // Series term k: multiply by x^2, divide by (2k-1)*2k through a reciprocal.
  for (genvar k = 1; k <= SS; k++) begin : g_term
    localparam int B = 3 * (k - 1);
    localparam logic [31:0] D = 32'((2 * k - 1) * (2 * k));
    localparam logic [31:0] R = 32'(64'h1_0000_0000 / D);
    localparam bit SUB = (k % 2) == 1;

    logic [63:0] np;
    logic [63:0] mp;
    logic [63:0] dp;
    logic [31:0] rem;
    logic [31:0] q;
    tstage_t     mul_next;
    tstage_t     rcp_next;
    tstage_t     fix_next;

    assign np  = 64'(tst[B].term) * 64'(tst[B].x2);
    assign mp  = 64'(tst[B+1].n) * 64'(R);
    assign dp  = 64'(tst[B+2].q0) * 64'(D);
    assign rem = tst[B+2].n - dp[31:0];
    assign q   = tst[B+2].q0 + 32'(rem >= D);

    always_comb begin
      mul_next      = tst[B];
      mul_next.n    = np[61:30];
      rcp_next      = tst[B+1];
      rcp_next.q0   = mp[63:32];
      fix_next      = tst[B+2];
      fix_next.term = q;
      fix_next.c    = SUB ? (tst[B+2].c - $signed(34'(q)))
                          : (tst[B+2].c + $signed(34'(q)));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tst[B+1] <= mul_next;
        tst[B+2] <= rcp_next;
        tst[B+3] <= fix_next;
      end
    end
  end

  // clamp the cosine to [0, 1], then weight = (1 - cos) / 2, or (1 + cos) / 2 for a folded phase
  logic signed [33:0] cf;
  logic [30:0]        cl;
  logic [31:0]        wsum;

  always_comb begin
    cf = tst[3*SS].c;
    if (cf[33]) begin
      cl = '0;
    end else if (cf > $signed(34'(ONE))) begin
      cl = ONE;
    end else begin
      cl = cf[30:0];
    end
    wsum = tst[3*SS].flip ? ({1'b0, ONE} + {1'b0, cl}) : ({1'b0, ONE} - {1'b0, cl});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weight   <= wsum[31:1];
      pass_out <= tst[3*SS].pass;
    end
  end

  assign out_valid = vld[LAT-1];

endmodule

/* sv/kfi_scale.sv */
module kfi_scale (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  kfi_pkg::pass_t            pass_in,
  input  logic [kfi_pkg::W_W-1:0]   weight,
  output logic                      out_valid,
  output logic signed [31:0]        value,
  output logic                      zero_span,
  output logic                      saturated
);

  localparam int NW   = kfi_pkg::NUM_W;
  localparam int DW   = kfi_pkg::DIFF_W;
  localparam int LO_W = (NW + 1) / 2;
  localparam int HI_W = NW - LO_W;
  localparam int PW   = DW + NW;
  localparam int CAP  = 34;

  logic [2:0] vld;

  // stage 1: split product
  logic [NW-1:0]        m;
  logic [DW+LO_W-1:0]   p_lo;
  logic [DW+HI_W-1:0]   p_hi;
  kfi_pkg::mode_t       mode1;
  logic                 neg1;
  logic                 zs1;
  logic signed [31:0]   v1_1;

  // stage 2: magnitude of delta, capped
  logic [PW-1:0]        prod;
  logic [PW-1:0]        sh;
  logic [CAP:0]         mag;
  logic [CAP:0]         mag2;
  logic                 neg2;
  logic                 zs2;
  logic signed [31:0]   v1_2;

  // stage 3
  logic signed [CAP+1:0] delta;
  logic signed [CAP+2:0] sum;

  always_comb begin
    m = (pass_in.side.mode == kfi_pkg::MODE_SINE) ? NW'(weight) : pass_in.fac_mag;
  end

  assign prod = {p_hi, {LO_W{1'b0}}} + PW'(p_lo);

  always_comb begin
    sh  = (mode1 == kfi_pkg::MODE_SINE) ? (prod >> 30) : (prod >> kfi_pkg::FRAC_BITS);
    mag = (|sh[PW-1:CAP]) ? ((CAP+1)'(1) << CAP) : (CAP+1)'(sh[CAP-1:0]);
  end

  always_comb begin
    delta = neg2 ? -$signed({1'b0, mag2}) : $signed({1'b0, mag2});
    sum   = (CAP+3)'(v1_2) + (CAP+3)'(delta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo  <= (DW+LO_W)'(pass_in.side.dv_mag) * (DW+LO_W)'(m[LO_W-1:0]);
      p_hi  <= (DW+HI_W)'(pass_in.side.dv_mag) * (DW+HI_W)'(m[NW-1:LO_W]);
      mode1 <= pass_in.side.mode;
      neg1  <= (pass_in.side.mode == kfi_pkg::MODE_SINE) ? pass_in.side.dv_neg
               : (pass_in.side.dv_neg ^ pass_in.side.fac_neg);
      zs1   <= pass_in.side.zero_span;
      v1_1  <= pass_in.side.value_start;

      mag2  <= mag;
      neg2  <= neg1;
      zs2   <= zs1;
      v1_2  <= v1_1;

      if (zs2) begin
        value     <= v1_2;
        saturated <= 1'b0;
      end else if (sum > (CAP+3)'(32'sh7FFF_FFFF)) begin
        value     <= 32'sh7FFF_FFFF;
        saturated <= 1'b1;
      end else if (sum < (CAP+3)'(32'sh8000_0000)) begin
        value     <= 32'sh8000_0000;
        saturated <= 1'b1;
      end else begin
        value     <= sum[31:0];
        saturated <= 1'b0;
      end
      zero_span <= zs2;
    end
  end

  assign out_valid = vld[2];

endmodule

/* sv/kfi_checker.sv */
`include "keyframe_interpolator_assert.svh"

module kfi_checker (
  input logic               clk,
  input logic               rst,
  input logic               query_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [31:0] value,
  input logic               zero_span,
  input logic               saturated
);

  `KFI_ASSERT_NOW(a_zero_span_no_sat, result_valid && zero_span, !saturated, "zero span item flagged saturated")
  `KFI_ASSERT_NOW(a_sat_at_rail, result_valid && saturated, (value == 32'sh7FFF_FFFF) || (value == 32'sh8000_0000), "saturated value not at a rail")
  `KFI_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(value) && $stable(saturated) && $stable(zero_span), "stalled result changed")
  `KFI_ASSERT_NOW(a_stall_cause, $rose(query_stall), $past(result_valid && result_stall), "input stalled without an output stall")

endmodule

bind keyframe_interpolator kfi_checker u_kfi_checker (.*);
